[src/w2sp_pkg.sv]
// constants and shared types for the weighted 2x2 subsample pool
// no dependencies
`timescale 1ns / 1ps

package w2sp_pkg;

   localparam int MAX_WIDTH    = 32;
   localparam int MAX_CHANNELS = 16;
   localparam int WINDOW_TAPS  = 4;
   localparam int ROW_LIMIT    = 64;

   localparam int DATA_W      = 16;
   localparam int CHANNEL_W   = 4;
   localparam int SLOT_W      = 3;
   localparam int OUT_ROW_W   = 5;
   localparam int OUT_COL_W   = 4;
   localparam int CFG_WIDTH_W  = 6;
   localparam int CFG_HEIGHT_W = 7;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(ROW_LIMIT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(ROW_LIMIT);
   localparam int LB_DEPTH = MAX_WIDTH / 2;
   localparam int LB_AW  = $clog2(LB_DEPTH);
   localparam int CH_AW  = $clog2(MAX_CHANNELS);

   localparam logic [W_W-1:0] WIDTH_RESET  = W_W'(28);
   localparam logic [H_W-1:0] HEIGHT_RESET = H_W'(28);

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_TABLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [SLOT_W-1:0] SLOT_BIAS = SLOT_W'(WINDOW_TAPS);

   typedef logic [DATA_W-1:0] word_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } meta_type;

endpackage

[src/weighted_2x2_subsample_pool.sv]
// weighted 2x2 subsample pool, stride 2, trainable weights and bias per channel
// uses w2sp_pkg; holds the weight table and line buffer memories
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  req     | req_valid/ready, cmd data ch slot   | in
//  rsp     | rsp_valid/ready, value ch row col   | out
//  csr     | csr_write, csr_index, csr_wdata     | in
//
// one item per cycle while the output is not stalled; a result leaves after its pixel
// transfer through the memory read, the multiply stage and the sum into the output register
// every stage stalls only when the stage after it is full, so bubbles collapse
// synchronous active-high reset clears counters, previous pixel and stage valids;
// the memories are not cleared
`timescale 1ns / 1ps

module weighted_2x2_subsample_pool (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic signed [w2sp_pkg::DATA_W-1:0] req_data,
   input  logic [w2sp_pkg::CHANNEL_W-1:0]   req_channel,
   input  logic [w2sp_pkg::SLOT_W-1:0]      req_slot,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [w2sp_pkg::DATA_W-1:0] rsp_pooled_value,
   output logic [w2sp_pkg::CHANNEL_W-1:0]   rsp_out_channel,
   output logic [w2sp_pkg::OUT_ROW_W-1:0]   rsp_out_row,
   output logic [w2sp_pkg::OUT_COL_W-1:0]   rsp_out_col,
   output logic                             rsp_plane_last,
   input  logic                             csr_write,
   input  logic [w2sp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [w2sp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import w2sp_pkg::*;

   function automatic logic [W_W-1:0] fit_width(input logic [CFG_WIDTH_W-1:0] v);
      logic [W_W-1:0] r;
      if (W_W'(v) < W_W'(2)) r = W_W'(2);
      else if (W_W'(v) > W_W'(MAX_WIDTH)) r = W_W'(MAX_WIDTH);
      else r = W_W'(v);
      r[0] = 1'b0;
      return r;
   endfunction

   function automatic logic [H_W-1:0] fit_height(input logic [CFG_HEIGHT_W-1:0] v);
      logic [H_W-1:0] r;
      if (H_W'(v) < H_W'(2)) r = H_W'(2);
      else if (H_W'(v) > H_W'(ROW_LIMIT)) r = H_W'(ROW_LIMIT);
      else r = H_W'(v);
      r[0] = 1'b0;
      return r;
   endfunction

   // memories
   word_type [WINDOW_TAPS:0] wt_mem [MAX_CHANNELS];
   word_type [1:0]           lb_mem [LB_DEPTH];
   word_type [WINDOW_TAPS:0] wt_rd_ff;
   word_type [1:0]           lb_rd_ff;

   // configuration and position state
   logic [W_W-1:0]   width_ff;
   logic [H_W-1:0]   height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   word_type         prev_ff;

   // stages
   logic       s1_v_ff, s1_v_in;
   word_type   s1_data_ff, s1_prev_ff;
   meta_type   s1_meta_ff, s1_meta_in;
   logic       p_v_ff;
   word_type [WINDOW_TAPS-1:0] p_prod_ff, p_prod_in;
   word_type   p_bias_ff;
   meta_type   p_meta_ff;
   logic       out_v_ff;
   word_type   out_value_ff, out_value_in;
   meta_type   out_meta_ff;

   logic s1_free, p_free, out_free;
   logic accept, pix_acc, wt_we, lb_we;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic [H_W-1:0]   row_pre;
   logic [W_W-1:0]   col_next;
   logic [H_W-1:0]   row_next;
   logic [LB_AW-1:0] lb_addr;
   logic signed [2*DATA_W-1:0] prod_full [WINDOW_TAPS];
   word_type [WINDOW_TAPS-1:0] px;

   assign out_free  = !out_v_ff || rsp_ready;
   assign p_free    = !p_v_ff || out_free;
   assign s1_free   = !s1_v_ff || p_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && s1_free;
   assign pix_acc   = accept && (req_cmd == CMD_PIXEL);
   assign wt_we     = accept && (req_cmd == CMD_TABLE) && (req_slot <= SLOT_BIAS)
                      && (32'(req_channel) < MAX_CHANNELS);

   // position of the incoming pixel, with counters past a shrunken size moved on
   always_comb begin
      col_cur = col_ff;
      row_pre = H_W'(row_ff);
      if (W_W'(col_ff) >= width_ff) begin
         col_cur = '0;
         row_pre = H_W'(row_pre + 1'b1);
      end
      if (row_pre >= height_ff) row_pre = '0;
      row_cur = row_pre[ROW_W-1:0];

      col_next = W_W'(col_cur) + 1'b1;
      row_next = H_W'(row_cur);
      col_in   = col_ff;
      row_in   = row_ff;
      if (pix_acc) begin
         if (col_next >= width_ff) begin
            col_in   = '0;
            row_next = H_W'(row_next + 1'b1);
            if (row_next >= height_ff) row_next = '0;
            row_in = row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   assign lb_addr = col_cur[COL_W-1:1];
   assign lb_we   = pix_acc && !row_cur[0];
   assign s1_v_in = pix_acc && row_cur[0] && col_cur[0];

   always_comb begin
      s1_meta_in.channel = req_channel;
      s1_meta_in.row     = row_cur[ROW_W-1:1];
      s1_meta_in.col     = col_cur[COL_W-1:1];
      s1_meta_in.last    = (H_W'(row_cur) == H_W'(height_ff - 1'b1))
                           && (W_W'(col_cur) == W_W'(width_ff - 1'b1));
   end

   // window taps: line buffer pair above, previous pixel and current pixel below
   always_comb begin
      px[0] = lb_rd_ff[0];
      px[1] = lb_rd_ff[1];
      px[2] = s1_prev_ff;
      px[3] = s1_data_ff;
      for (int k = 0; k < WINDOW_TAPS; k++) begin
         prod_full[k] = $signed(px[k]) * $signed(wt_rd_ff[k]);
         p_prod_in[k] = prod_full[k][DATA_W-1:0];
      end
   end

   assign out_value_in = p_prod_ff[0] + p_prod_ff[1] + p_prod_ff[2] + p_prod_ff[3]
                         + p_bias_ff;

   // weight table, one row per channel, one lane per slot
   always_ff @(posedge clock) begin
      if (wt_we) wt_mem[req_channel[CH_AW-1:0]][req_slot] <= req_data;
      if (s1_free) wt_rd_ff <= wt_mem[req_channel[CH_AW-1:0]];
   end

   // line buffer, one row per column pair
   always_ff @(posedge clock) begin
      if (lb_we) lb_mem[lb_addr][col_cur[0]] <= req_data;
      if (s1_free) lb_rd_ff <= lb_mem[lb_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= fit_width(csr_wdata[CFG_WIDTH_W-1:0]);
            REG_IMAGE_HEIGHT: height_ff <= fit_height(csr_wdata[CFG_HEIGHT_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         prev_ff  <= '0;
         s1_v_ff  <= 1'b0;
         p_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (pix_acc) prev_ff <= req_data;
         if (s1_free) s1_v_ff <= s1_v_in;
         if (p_free) p_v_ff <= s1_v_ff;
         if (out_free) out_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_data_ff <= req_data;
         s1_prev_ff <= prev_ff;
         s1_meta_ff <= s1_meta_in;
      end
      if (p_free) begin
         p_prod_ff <= p_prod_in;
         p_bias_ff <= wt_rd_ff[WINDOW_TAPS];
         p_meta_ff <= s1_meta_ff;
      end
      if (out_free) begin
         out_value_ff <= out_value_in;
         out_meta_ff  <= p_meta_ff;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_pooled_value = out_value_ff;
   assign rsp_out_channel  = out_meta_ff.channel;
   assign rsp_out_row      = out_meta_ff.row;
   assign rsp_out_col      = out_meta_ff.col;
   assign rsp_plane_last   = out_meta_ff.last;

`ifndef SYNTHESIS
   a_window_enters: assert property (@(posedge clock) disable iff (reset)
      (pix_acc && row_cur[0] && col_cur[0]) |=> s1_v_ff)
      else $error("completed window did not enter the pipeline");

   a_table_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_TABLE) |=> !s1_v_ff)
      else $error("table write produced a result");

   a_mult_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !p_v_ff) |=> p_v_ff)
      else $error("window stalled in front of an empty multiply stage");

   a_sum_advance: assert property (@(posedge clock) disable iff (reset)
      (p_v_ff && !out_v_ff) |=> out_v_ff)
      else $error("products stalled in front of an empty output register");
`endif

endmodule
